// ===== rtl/quaternion_arith_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITH_UNIT_MACROS_SVH
`define QUATERNION_ARITH_UNIT_MACROS_SVH

// antecedent implies consequent on the same edge
`define QAU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold
`define QAU_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Default widths, operation codes and the control word of the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

	localparam int COMP_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	typedef enum logic [1:0] {
		KIND_MUL  = 2'd0,
		KIND_NORM = 2'd1,
		KIND_ROT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic       vld;
		kind_t      kind;
		logic [3:0] neg;
		logic       nzero;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/qau_prod.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit product stage
// Registered 4x4 array of component products a_i * b_j.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_prod import qau_pkg::*; #(
	parameter int W = COMP_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_t                  ctl_in,
	input  wire logic signed [W-1:0]   a [4],
	input  wire logic signed [W-1:0]   b [4],
	output      ctl_t                  ctl_out,
	output      logic signed [2*W-1:0] p [4][4]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p[i][j] <= (2*W)'(a[i]) * (2*W)'(b[j]);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/qau_comb.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit combine stage
// Sums the products into result entries, the squared norm and squared parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_comb import qau_pkg::*; #(
	parameter int W = COMP_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctl_t                    ctl_in,
	input  wire logic signed [2*W-1:0]   p [4][4],
	output      ctl_t                    ctl_out,
	output      logic signed [2*W+2:0]   e [9],
	output      logic        [2*W:0]     n,
	output      logic        [2*W-1:0]   r [4]
);

	localparam int SW = 2*W + 3;
	localparam int NW = 2*W + 1;
	localparam logic signed [SW-1:0] ONE_SQ = SW'(1) << (2*F);

	logic signed [SW-1:0] x [4][4];
	logic signed [SW-1:0] e_d [9];
	logic        [NW-1:0] n_d;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				x[i][j] = SW'(p[i][j]);
			end
		end
		n_d = NW'($unsigned(p[0][0])) + NW'($unsigned(p[1][1]))
			+ NW'($unsigned(p[2][2])) + NW'($unsigned(p[3][3]));
		for (int i = 0; i < 9; i++) begin
			e_d[i] = '0;
		end
		case (ctl_in.kind)
			KIND_MUL: begin
				e_d[0] = x[3][0] + x[0][3] + x[1][2] - x[2][1];
				e_d[1] = x[3][1] + x[1][3] + x[2][0] - x[0][2];
				e_d[2] = x[3][2] + x[2][3] + x[0][1] - x[1][0];
				e_d[3] = x[3][3] - x[0][0] - x[1][1] - x[2][2];
			end
			KIND_ROT: begin
				e_d[0] = ONE_SQ - ((x[1][1] + x[2][2]) <<< 1);
				e_d[1] = (x[0][1] + x[3][2]) <<< 1;
				e_d[2] = (x[0][2] - x[3][1]) <<< 1;
				e_d[3] = (x[0][1] - x[3][2]) <<< 1;
				e_d[4] = ONE_SQ - ((x[0][0] + x[2][2]) <<< 1);
				e_d[5] = (x[1][2] + x[3][0]) <<< 1;
				e_d[6] = (x[0][2] + x[3][1]) <<< 1;
				e_d[7] = (x[1][2] - x[3][0]) <<< 1;
				e_d[8] = ONE_SQ - ((x[0][0] + x[1][1]) <<< 1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= '{vld: ctl_in.vld, kind: ctl_in.kind, neg: ctl_in.neg,
				nzero: (n_d == '0)};
		end
	end

	always_ff @(posedge clk) begin
		e <= e_d;
		n <= n_d;
		for (int i = 0; i < 4; i++) begin
			r[i] <= $unsigned(p[i][i]);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/qau_rsqrt_lane.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit normalise lane
// One result bit per stage: largest q with (2q-1)^2 * n <= c^2 * 2^(2F+2),
// n*q^2 and n*q kept as running sums so no stage needs a multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_rsqrt_lane import qau_pkg::*; #(
	parameter int W = COMP_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic [2*W:0]   n,
	input  wire logic [2*W-1:0] r,
	output      logic [F:0]     q
);

	localparam int XW = 2*W + 2*F + 4;

	logic [XW-1:0] n_s     [F+1];
	logic [XW-1:0] rr_s    [F+1];
	logic [XW-1:0] acc_a_s [F+1];
	logic [XW-1:0] acc_b_s [F+1];
	logic [F:0]    q_s     [F+1];

	for (genvar j = 0; j <= F; j++) begin : g_stage
		localparam int BIT = F - j;
		localparam logic [F:0] BITMASK = (F+1)'(1) << BIT;

		logic [XW-1:0] pn, pr, pa, pb, sq, lin, tst;
		logic [F:0]    pq;
		logic          take;

		if (j == 0) begin : g_first
			assign pn = XW'(n);
			assign pr = XW'(r) << (2*F + 2);
			assign pa = '0;
			assign pb = '0;
			assign pq = '0;
		end else begin : g_next
			assign pn = n_s[j-1];
			assign pr = rr_s[j-1];
			assign pa = acc_a_s[j-1];
			assign pb = acc_b_s[j-1];
			assign pq = q_s[j-1];
		end

		assign sq   = pa + (pb << (BIT + 1)) + (pn << (2*BIT));
		assign lin  = pb + (pn << BIT);
		assign tst  = (sq << 2) - (lin << 2) + pn;
		assign take = !pq[F] && (tst <= pr);

		always_ff @(posedge clk) begin
			n_s[j]     <= pn;
			rr_s[j]    <= pr;
			acc_a_s[j] <= take ? sq : pa;
			acc_b_s[j] <= take ? lin : pb;
			q_s[j]     <= take ? (pq | BITMASK) : pq;
		end
	end

	assign q = q_s[F];

endmodule

`default_nettype wire

// ===== rtl/quaternion_arith_unit.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Pipelined Hamilton product, normalise and rotation matrix in fixed point.
// ----------------------------------------------------------------------------
// A new item may be started in every cycle; busy stays low. Each item passes
// the input, product, combine, normalise and output registers and leaves
// with done high for one cycle; results come out in the order given. The
// depth is set by the normalise lanes, which settle one result bit per stage;
// the other kinds are delayed to match. The receiver cannot stall the unit,
// so results must be taken in the cycle that done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_arith_unit_macros.svh"

module quaternion_arith_unit import qau_pkg::*; #(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output      logic                         busy,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [COMP_WIDTH-1:0] a_x,
	input  wire logic signed [COMP_WIDTH-1:0] a_y,
	input  wire logic signed [COMP_WIDTH-1:0] a_z,
	input  wire logic signed [COMP_WIDTH-1:0] a_w,
	input  wire logic signed [COMP_WIDTH-1:0] b_x,
	input  wire logic signed [COMP_WIDTH-1:0] b_y,
	input  wire logic signed [COMP_WIDTH-1:0] b_z,
	input  wire logic signed [COMP_WIDTH-1:0] b_w,
	output      logic                         done,
	output      logic signed [COMP_WIDTH-1:0] res_0,
	output      logic signed [COMP_WIDTH-1:0] res_1,
	output      logic signed [COMP_WIDTH-1:0] res_2,
	output      logic signed [COMP_WIDTH-1:0] res_3,
	output      logic signed [COMP_WIDTH-1:0] res_4,
	output      logic signed [COMP_WIDTH-1:0] res_5,
	output      logic signed [COMP_WIDTH-1:0] res_6,
	output      logic signed [COMP_WIDTH-1:0] res_7,
	output      logic signed [COMP_WIDTH-1:0] res_8,
	output      logic                         flag
);

	localparam int W   = COMP_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int SW  = 2*W + 3;
	localparam int LAT = F + 5;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);
	localparam logic signed [SW-1:0] HI_S = (SW'(1) << (W - 1)) - SW'(1);
	localparam logic signed [SW-1:0] LO_S = -(SW'(1) << (W - 1));
	localparam logic [W:0]           HI_M = (W+1)'(HI_S);

	ctl_t                  ctl_s1, ctl_s2, ctl_s3;
	logic signed [W-1:0]   a_s1 [4];
	logic signed [W-1:0]   b_s1 [4];
	logic signed [2*W-1:0] p_s2 [4][4];
	logic signed [SW-1:0]  e_s3 [9];
	logic [2*W:0]          n_s3;
	logic [2*W-1:0]        r_s3 [4];
	logic [F:0]            q_lane [4];

	ctl_t                  dly_ctl_s [F+1];
	logic signed [W-1:0]   dly_ent_s [F+1][9];
	logic                  dly_flg_s [F+1];

	logic signed [W-1:0]   ent_d [9];
	logic                  flg_d;
	logic signed [W-1:0]   res_d [9];
	logic                  rflg_d;
	logic signed [W-1:0]   res_q [9];
	logic                  done_q, flag_q;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld   <= start && !busy;
			ctl_s1.kind  <= kind_t'(kind);
			ctl_s1.neg   <= {a_w[W-1], a_z[W-1], a_y[W-1], a_x[W-1]};
			ctl_s1.nzero <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= '{a_x, a_y, a_z, a_w};
		if (kind_t'(kind) == KIND_MUL) begin
			b_s1 <= '{b_x, b_y, b_z, b_w};
		end else begin
			b_s1 <= '{a_x, a_y, a_z, a_w};
		end
	end

	qau_prod #(.W(W)) u_prod (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s1),
		.a       (a_s1),
		.b       (b_s1),
		.ctl_out (ctl_s2),
		.p       (p_s2)
	);

	qau_comb #(.W(W), .F(F)) u_comb (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s2),
		.p       (p_s2),
		.ctl_out (ctl_s3),
		.e       (e_s3),
		.n       (n_s3),
		.r       (r_s3)
	);

	for (genvar i = 0; i < 4; i++) begin : g_lane
		qau_rsqrt_lane #(.W(W), .F(F)) u_lane (
			.clk (clk),
			.n   (n_s3),
			.r   (r_s3[i]),
			.q   (q_lane[i])
		);
	end

	// round to nearest and clamp
	always_comb begin
		logic signed [SW-1:0] sh;
		flg_d = 1'b0;
		for (int i = 0; i < 9; i++) begin
			sh = (e_s3[i] + HALF) >>> F;
			if (sh > HI_S) begin
				ent_d[i] = W'(HI_S);
				flg_d    = 1'b1;
			end else if (sh < LO_S) begin
				ent_d[i] = W'(LO_S);
				flg_d    = 1'b1;
			end else begin
				ent_d[i] = sh[W-1:0];
			end
		end
	end

	// hold rounded entries alongside the normalise lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= F; j++) begin
				dly_ctl_s[j] <= '0;
			end
		end else begin
			dly_ctl_s[0] <= ctl_s3;
			for (int j = 1; j <= F; j++) begin
				dly_ctl_s[j] <= dly_ctl_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dly_ent_s[0] <= ent_d;
		dly_flg_s[0] <= flg_d;
		for (int j = 1; j <= F; j++) begin
			dly_ent_s[j] <= dly_ent_s[j-1];
			dly_flg_s[j] <= dly_flg_s[j-1];
		end
	end

	always_comb begin
		logic [W:0] mm;
		logic [W:0] val;
		mm     = '0;
		val    = '0;
		res_d  = dly_ent_s[F];
		rflg_d = dly_flg_s[F];
		if (dly_ctl_s[F].kind == KIND_NORM) begin
			for (int i = 0; i < 9; i++) begin
				res_d[i] = '0;
			end
			rflg_d = dly_ctl_s[F].nzero;
			if (!dly_ctl_s[F].nzero) begin
				for (int i = 0; i < 4; i++) begin
					mm = (W+1)'(q_lane[i]);
					if (!dly_ctl_s[F].neg[i] && mm > HI_M) begin
						res_d[i] = W'(HI_S);
						rflg_d   = 1'b1;
					end else begin
						val      = dly_ctl_s[F].neg[i] ? -mm : mm;
						res_d[i] = val[W-1:0];
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dly_ctl_s[F].vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_d;
		flag_q <= rflg_d;
	end

	assign done  = done_q;
	assign flag  = flag_q;
	assign res_0 = res_q[0];
	assign res_1 = res_q[1];
	assign res_2 = res_q[2];
	assign res_3 = res_q[3];
	assign res_4 = res_q[4];
	assign res_5 = res_q[5];
	assign res_6 = res_q[6];
	assign res_7 = res_q[7];
	assign res_8 = res_q[8];

	`QAU_ASSERT_IMP(a_done_follows_start, done, $past(start, LAT), "done without a transfer")
	`QAU_ASSERT_IMP(a_zero_norm_flag,
		done && $past(kind, LAT) == KIND_NORM && $past(a_x, LAT) == 0 && $past(a_y, LAT) == 0 &&
		$past(a_z, LAT) == 0 && $past(a_w, LAT) == 0, flag, "zero norm not flagged")
	`QAU_ASSERT_NEVER(a_matrix_only,
		done && $past(kind, LAT) != KIND_ROT && (res_4 != 0 || res_5 != 0 || res_6 != 0 ||
		res_7 != 0 || res_8 != 0), "matrix entries set for a quaternion result")

endmodule

`default_nettype wire

// ===== test/quaternion_arith_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Drives directed items, then multiply, normalise and rotation-matrix items
// in bursts with random gaps. A behavioural predictor computes each result,
// and every done strobe is checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_arith_unit_tb;
	import qau_pkg::*;

	localparam int CW = 16;
	localparam int FB = 14;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam longint HALF_LSB = longint'(1) << (FB - 1);
	localparam longint ONE_SQ = longint'(1) << (2 * FB);
	localparam longint COMP_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint COMP_MIN = -(longint'(1) << (CW - 1));
	localparam int DRAIN_CYCLES = FB + 12;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic signed [CW-1:0] comp_t;

	typedef struct packed {
		logic [8:0][CW-1:0] res;
		logic               flag;
	} quat_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] kind = KIND_MUL;
	comp_t a_x = '0, a_y = '0, a_z = '0, a_w = '0;
	comp_t b_x = '0, b_y = '0, b_z = '0, b_w = '0;
	logic busy, done, flag;
	comp_t res_0, res_1, res_2, res_3, res_4, res_5, res_6, res_7, res_8;

	quat_result_t expected_results[$];
	int mismatches = 0;
	int cycles = 0;

	quaternion_arith_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
		.done(done), .res_0(res_0), .res_1(res_1), .res_2(res_2), .res_3(res_3),
		.res_4(res_4), .res_5(res_5), .res_6(res_6), .res_7(res_7), .res_8(res_8),
		.flag(flag)
	);

	always #4 clk = ~clk;

	function automatic logic [CW-1:0] clamp_comp(longint v, inout logic f);
		if (v > COMP_MAX) begin
			v = COMP_MAX;
			f = 1'b1;
		end
		if (v < COMP_MIN) begin
			v = COMP_MIN;
			f = 1'b1;
		end
		return v[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] round_comp(longint v, inout logic f);
		return clamp_comp((v + HALF_LSB) >>> FB, f);
	endfunction

	function automatic longint unit_magnitude(longint c, longint unsigned n);
		longint unsigned mag, rhs, q, cand, d;
		mag = (c < 0) ? -c : c;
		rhs = (mag * mag) << (2 * FB + 2);
		q = 0;
		for (int b = FB; b >= 0; b--) begin
			cand = q | (longint'(1) << b);
			if (cand <= (longint'(1) << FB)) begin
				d = 2 * cand - 1;
				if (d * d * n <= rhs)
					q = cand;
			end
		end
		return longint'(q);
	endfunction

	function automatic quat_result_t quat_arith(logic [1:0] k, comp_t qa[4], comp_t qb[4]);
		quat_result_t r;
		longint ax, ay, az, aw, bx, by, bz, bw, m;
		longint unsigned n;
		logic f;
		ax = qa[0]; ay = qa[1]; az = qa[2]; aw = qa[3];
		bx = qb[0]; by = qb[1]; bz = qb[2]; bw = qb[3];
		r = '0;
		f = 1'b0;
		case (k)
			KIND_MUL: begin
				r.res[0] = round_comp(aw * bx + bw * ax + (ay * bz - az * by), f);
				r.res[1] = round_comp(aw * by + bw * ay + (az * bx - ax * bz), f);
				r.res[2] = round_comp(aw * bz + bw * az + (ax * by - ay * bx), f);
				r.res[3] = round_comp(aw * bw - (ax * bx + ay * by + az * bz), f);
			end
			KIND_NORM: begin
				n = ax * ax + ay * ay + az * az + aw * aw;
				if (n == 0)
					f = 1'b1;
				else begin
					for (int i = 0; i < 4; i++) begin
						m = unit_magnitude(longint'(qa[i]), n);
						r.res[i] = clamp_comp((qa[i] < 0) ? -m : m, f);
					end
				end
			end
			KIND_ROT: begin
				r.res[0] = round_comp(ONE_SQ - 2 * (ay * ay + az * az), f);
				r.res[1] = round_comp(2 * (ax * ay + aw * az), f);
				r.res[2] = round_comp(2 * (ax * az - aw * ay), f);
				r.res[3] = round_comp(2 * (ax * ay - aw * az), f);
				r.res[4] = round_comp(ONE_SQ - 2 * (ax * ax + az * az), f);
				r.res[5] = round_comp(2 * (ay * az + aw * ax), f);
				r.res[6] = round_comp(2 * (ax * az + aw * ay), f);
				r.res[7] = round_comp(2 * (ay * az - aw * ax), f);
				r.res[8] = round_comp(ONE_SQ - 2 * (ax * ax + ay * ay), f);
			end
			default: ;
		endcase
		r.flag = f;
		return r;
	endfunction

	// hold the item until the transfer, then queue its prediction
	task automatic send_item(logic [1:0] k, comp_t qa[4], comp_t qb[4]);
		@(negedge clk);
		start = 1'b1;
		kind = k;
		{a_x, a_y, a_z, a_w} = {qa[0], qa[1], qa[2], qa[3]};
		{b_x, b_y, b_z, b_w} = {qb[0], qb[1], qb[2], qb[3]};
		do
			@(posedge clk);
		while (busy);
		expected_results.push_back(quat_arith(k, qa, qb));
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	function automatic comp_t random_comp();
		case ($urandom_range(0, 5))
			0: return comp_t'($urandom_range(0, 1) ? COMP_MAX : COMP_MIN);
			1: return '0;
			2, 3: return comp_t'(int'($urandom_range(0, 32768)) - 16384);
			default: return comp_t'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic random_bursts(int items, logic [1:0] fixed_kind, bit mixed);
		comp_t qa[4], qb[4];
		logic [1:0] k;
		int burst;
		while (items > 0) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && items > 0; j++) begin
				for (int i = 0; i < 4; i++) begin
					qa[i] = random_comp();
					qb[i] = random_comp();
				end
				k = mixed ? 2'($urandom_range(0, 2)) : fixed_kind;
				send_item(k, qa, qb);
				items--;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 12));
		end
		idle_cycles(1);
	endtask

	task automatic test_directed();
		comp_t z[4], ident[4], hi[4], lo[4], tiny[4], mixd[4];
		z = '{default: '0};
		ident = '{0, 0, 0, 16384};
		hi = '{default: comp_t'(COMP_MAX)};
		lo = '{default: comp_t'(COMP_MIN)};
		tiny = '{1, 0, 0, 0};
		mixd = '{comp_t'(COMP_MIN), comp_t'(COMP_MAX), 16384, -16384};
		send_item(KIND_MUL, ident, ident);
		send_item(KIND_MUL, z, hi);
		send_item(KIND_MUL, hi, hi);
		send_item(KIND_MUL, lo, lo);
		send_item(KIND_MUL, hi, lo);
		send_item(KIND_MUL, mixd, ident);
		send_item(KIND_MUL, mixd, mixd);
		send_item(KIND_NORM, z, hi);
		send_item(KIND_NORM, ident, z);
		send_item(KIND_NORM, tiny, z);
		send_item(KIND_NORM, hi, z);
		send_item(KIND_NORM, lo, z);
		send_item(KIND_NORM, mixd, z);
		send_item(KIND_NORM, '{0, comp_t'(COMP_MIN), 0, 0}, z);
		send_item(KIND_ROT, ident, z);
		send_item(KIND_ROT, z, z);
		send_item(KIND_ROT, hi, z);
		send_item(KIND_ROT, lo, z);
		send_item(KIND_ROT, mixd, z);
		send_item(KIND_ROT, tiny, lo);
		send_item(KIND_UNUSED, hi, lo);
		idle_cycles(3);
	endtask

	task automatic test_multiply();
		random_bursts(300, KIND_MUL, 1'b0);
	endtask

	task automatic test_normalise();
		random_bursts(300, KIND_NORM, 1'b0);
	endtask

	task automatic test_rotation_matrix();
		random_bursts(300, KIND_ROT, 1'b0);
	endtask

	task automatic test_mixed_stream();
		random_bursts(500, KIND_MUL, 1'b1);
	endtask

	always @(posedge clk) begin
		quat_result_t got, want;
		if (arst_n && done) begin
			got.res = {res_8, res_7, res_6, res_5, res_4, res_3, res_2, res_1, res_0};
			got.flag = flag;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: res %h flag %b", got.res, got.flag);
			end else begin
				want = expected_results.pop_front();
				if (got.res !== want.res || got.flag !== want.flag) begin
					mismatches++;
					if (mismatches <= 10) begin
						for (int i = 0; i < 9; i++)
							if (got.res[i] !== want.res[i])
								$display("res_%0d mismatch: expected %h actual %h",
									i, want.res[i], got.res[i]);
						if (got.flag !== want.flag)
							$display("flag mismatch: expected %b actual %b",
								want.flag, got.flag);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("quaternion_arith_unit_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_multiply();
		test_normalise();
		test_rotation_matrix();
		test_mixed_stream();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("quaternion_arith_unit_tb passed");
		else
			$display("quaternion_arith_unit_tb failed");
		$finish;
	end

endmodule
